@@ rtl/dfmt_pkg.sv @@
// Package for the decimal record formatter: transaction payload types, character
// codes, the control word layout and the microcode program of the sequencer.
// Depends on nothing; every other file of the block imports it.
package dfmt_pkg;

  // Input transaction: one measurement record.
  typedef struct packed {
    logic [7:0]  angle;
    logic [31:0] distance;
  } in_t;

  // Output transaction: one ASCII character of the record.
  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_t;

  // Character codes.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  // Digit stack: a 32-bit value has at most ten decimal digits.
  localparam int MAX_DIGITS = 10;
  localparam int CNT_W      = 4;

  // Divide by ten through the reciprocal 0xCCCCCCCD scaled by 2**35.
  localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
  localparam int          RECIP_SH = 35;
  localparam int          QUOT_W   = 64 - RECIP_SH;

  // Program counter width and step addresses.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_WAIT   = 4'd0;
  localparam logic [STEP_W-1:0] ST_A_MUL  = 4'd1;
  localparam logic [STEP_W-1:0] ST_A_PUSH = 4'd2;
  localparam logic [STEP_W-1:0] ST_A_POP  = 4'd3;
  localparam logic [STEP_W-1:0] ST_COMMA  = 4'd4;
  localparam logic [STEP_W-1:0] ST_D_MUL  = 4'd5;
  localparam logic [STEP_W-1:0] ST_D_PUSH = 4'd6;
  localparam logic [STEP_W-1:0] ST_D_POP  = 4'd7;
  localparam logic [STEP_W-1:0] ST_CR     = 4'd8;
  localparam logic [STEP_W-1:0] ST_LF     = 4'd9;

  // Source of a load into the working value register.
  typedef enum logic [1:0] {
    LD_NONE,
    LD_ANGLE,
    LD_DIST
  } load_sel_t;

  // Branch condition of a step.
  typedef enum logic [2:0] {
    COND_NEXT,     // fall through to the following step
    COND_WAIT,     // stay at the target until a transaction starts
    COND_QUOT_NZ,  // jump to the target while the quotient is non-zero
    COND_MORE,     // jump to the target while digits remain after this pop
    COND_JUMP      // jump to the target unconditionally
  } cond_t;

  // One control word.
  typedef struct packed {
    load_sel_t         load;
    logic              mul;
    logic              push;
    logic              pop;
    logic              emit;
    logic [7:0]        chr;
    logic              last;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // The microcode ROM.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '{load: LD_NONE, mul: 1'b0, push: 1'b0, pop: 1'b0, emit: 1'b0,
          chr: 8'h00, last: 1'b0, cond: COND_JUMP, target: ST_WAIT};
    unique case (step)
      ST_WAIT: begin
        c.load   = LD_ANGLE;
        c.cond   = COND_WAIT;
        c.target = ST_WAIT;
      end
      ST_A_MUL: begin
        c.mul  = 1'b1;
        c.cond = COND_NEXT;
      end
      ST_A_PUSH: begin
        c.push   = 1'b1;
        c.cond   = COND_QUOT_NZ;
        c.target = ST_A_MUL;
      end
      ST_A_POP: begin
        c.pop    = 1'b1;
        c.emit   = 1'b1;
        c.cond   = COND_MORE;
        c.target = ST_A_POP;
      end
      ST_COMMA: begin
        c.emit = 1'b1;
        c.chr  = CHAR_COMMA;
        c.load = LD_DIST;
        c.cond = COND_NEXT;
      end
      ST_D_MUL: begin
        c.mul  = 1'b1;
        c.cond = COND_NEXT;
      end
      ST_D_PUSH: begin
        c.push   = 1'b1;
        c.cond   = COND_QUOT_NZ;
        c.target = ST_D_MUL;
      end
      ST_D_POP: begin
        c.pop    = 1'b1;
        c.emit   = 1'b1;
        c.cond   = COND_MORE;
        c.target = ST_D_POP;
      end
      ST_CR: begin
        c.emit = 1'b1;
        c.chr  = CHAR_CR;
        c.cond = COND_NEXT;
      end
      ST_LF: begin
        c.emit   = 1'b1;
        c.chr    = CHAR_LF;
        c.last   = 1'b1;
        c.cond   = COND_JUMP;
        c.target = ST_WAIT;
      end
      default: begin
        c.cond   = COND_JUMP;
        c.target = ST_WAIT;
      end
    endcase
    return c;
  endfunction

endpackage

@@ rtl/dfmt_div10.sv @@
// Divide-by-ten quotient unit: one reciprocal multiplication per enabled cycle,
// with the quotient registered. Depends on dfmt_pkg.
module dfmt_div10 (
  input  logic                       clk,
  input  logic                       en,
  input  logic [31:0]                value,
  output logic [dfmt_pkg::QUOT_W-1:0] quot
);
  import dfmt_pkg::*;

  logic [63:0]        product;
  logic [QUOT_W-1:0]  quot_r;

  // Floor of value / 10, exact for every 32-bit value.
  assign product = 64'(value) * 64'(RECIP_10);

  always_ff @(posedge clk) begin
    if (en) begin
      quot_r <= product[63:RECIP_SH];
    end
  end

  assign quot = quot_r;

endmodule

@@ rtl/decimal_record_formatter.sv @@
// Decimal record formatter: prints angle, comma, distance, CR and LF, one character per strobe.
// The angle digits are formed by multiply and push steps and then popped most significant first,
// followed by the comma, the distance digits in the same way, CR and LF; start is ignored while busy.
// Each digit takes a multiply step and a push step of the divide-by-ten unit; each digit is sent by a pop.
// The receiver cannot stall; busy is low again in the cycle that carries the closing line feed.
// Synchronous active-low reset returns the sequencer to its wait step with no output pending.
module decimal_record_formatter #(
  parameter int ANGLE_BITS    = 8,
  parameter int DISTANCE_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  dfmt_pkg::in_t   in_data,
  output logic            out_valid,
  output dfmt_pkg::out_t  out_data
);
  import dfmt_pkg::*;

  localparam logic [7:0]  ANGLE_MASK = 8'((64'd1 << ANGLE_BITS) - 64'd1);
  localparam logic [31:0] DIST_MASK  = 32'((64'd1 << DISTANCE_BITS) - 64'd1);

  logic [STEP_W-1:0]             step_r, step_nxt;
  ctrl_t                         ctrl;
  logic [31:0]                   val_r, val_nxt;
  logic [31:0]                   dist_r;
  logic [QUOT_W-1:0]             quot;
  logic [31:0]                   rem_full;
  logic [3:0]                    digit;
  logic [MAX_DIGITS-1:0][3:0]    stack_r;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          out_valid_r;
  out_t                          out_data_r;
  logic [7:0]                    chr;
  logic                          accept;

  // Current control word from the program.
  assign ctrl   = ucode(step_r);
  assign busy   = (step_r != ST_WAIT);
  assign accept = start && !busy;

  dfmt_div10 u_div10 (
    .clk   (clk),
    .en    (ctrl.mul),
    .value (val_r),
    .quot  (quot)
  );

  // Remainder of the value against ten times its quotient gives the next digit.
  assign rem_full = val_r - {quot, 3'b000} - {2'b00, quot, 1'b0};
  assign digit    = rem_full[3:0];

  // Sequencer: step counter with conditional jumps.
  always_comb begin
    step_nxt = step_r + 1'b1;
    unique case (ctrl.cond)
      COND_NEXT:    step_nxt = step_r + 1'b1;
      COND_WAIT:    step_nxt = start ? step_r + 1'b1 : ctrl.target;
      COND_QUOT_NZ: step_nxt = (quot != '0) ? ctrl.target : step_r + 1'b1;
      COND_MORE:    step_nxt = (cnt_r != CNT_W'(1)) ? ctrl.target : step_r + 1'b1;
      COND_JUMP:    step_nxt = ctrl.target;
      default:      step_nxt = ST_WAIT;
    endcase
  end

  // Working value: loaded from a field or replaced by the quotient after a push.
  always_comb begin
    val_nxt = val_r;
    if (ctrl.push) begin
      val_nxt = 32'(quot);
    end else begin
      unique case (ctrl.load)
        LD_ANGLE: if (accept) val_nxt = {24'd0, in_data.angle & ANGLE_MASK};
        LD_DIST:  val_nxt = dist_r;
        LD_NONE:  val_nxt = val_r;
        default:  val_nxt = val_r;
      endcase
    end
  end

  // Digit count follows pushes and pops.
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.push) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (ctrl.pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Emitted character: a popped digit or the constant of the step.
  assign chr = ctrl.pop ? (CHAR_ZERO + {4'd0, stack_r[0]}) : ctrl.chr;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_WAIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= ctrl.emit;
    end
  end

  // Payload registers: value, distance hold, digit stack and output character.
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (accept) begin
      dist_r <= in_data.distance & DIST_MASK;
    end
    if (ctrl.push) begin
      stack_r <= {stack_r[MAX_DIGITS-2:0], digit};
    end else if (ctrl.pop) begin
      stack_r <= {4'd0, stack_r[MAX_DIGITS-1:1]};
    end
    out_data_r.character <= chr;
    out_data_r.last      <= ctrl.last;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
